// ===== design/assert_macros.svh =====
// assertion macros shared by the uart fifo block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/uft_pkg.sv =====
// types and constants of the uart fifo watermark block
package uft_pkg;

  localparam int TX_DEPTH  = 8;
  localparam int RX_DEPTH  = 8;
  localparam int DIV_RESET = 868;

  localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int WM_W     = 3;
  localparam int TX_CMP_W = (TX_CNT_W > WM_W) ? TX_CNT_W : WM_W;
  localparam int RX_CMP_W = (RX_CNT_W > WM_W) ? RX_CNT_W : WM_W;

  localparam int CTRL_W   = 19;
  localparam int WM_LSB   = 16;
  localparam logic [CTRL_W-1:0] CTRL_MASK = 19'h70003;
  localparam int FLAG_BIT = 31;
  localparam int DIV_W    = 16;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 64;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_RX_BYTE,
    KIND_TX_READY
  } kind_t;

  typedef enum logic [2:0] {
    REG_TXDATA,
    REG_RXDATA,
    REG_TXCTRL,
    REG_RXCTRL,
    REG_IE,
    REG_IP,
    REG_DIV,
    REG_UNMAPPED
  } reg_t;

  typedef struct packed {
    kind_t       kind;
    reg_t        addr;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             tx_two_stop;
    logic             tx_irq;
    logic             rx_irq;
    logic             rx_dropped;
    logic [DIV_W-1:0] baud_divisor;
  } res_t;

endpackage

// ===== design/uft_front.sv =====
// front end: takes input beats and turns them into queued commands
module uft_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [uft_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [uft_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output uft_pkg::cmd_t                 q_cmd
);

  uft_pkg::kind_t kind;

  assign kind     = uft_pkg::kind_t'(s_tuser);
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.kind = kind;
    q_cmd.addr = uft_pkg::reg_t'(s_tdata[2:0]);
    if (kind == uft_pkg::KIND_RX_BYTE) begin
      q_cmd.data = {24'd0, s_tdata[42:35]};
    end else begin
      q_cmd.data = s_tdata[34:3];
    end
  end

endmodule

// ===== design/uft_cmd_fifo.sv =====
// short command queue between front and back
`include "assert_macros.svh"
module uft_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uft_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output uft_pkg::cmd_t head_cmd,
  input  logic          pop
);

  uft_pkg::cmd_t                    entries [uft_pkg::CMDQ_DEPTH];
  logic [uft_pkg::CMDQ_PTR_W-1:0]   wr_ptr;
  logic [uft_pkg::CMDQ_PTR_W-1:0]   rd_ptr;
  logic [uft_pkg::CMDQ_CNT_W-1:0]   cnt;

  assign full     = (cnt == uft_pkg::CMDQ_CNT_W'(uft_pkg::CMDQ_DEPTH));
  assign valid    = (cnt != '0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == uft_pkg::CMDQ_PTR_W'(uft_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == uft_pkg::CMDQ_PTR_W'(uft_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ASSERT_HOLDS(a_cmdq_bound, cnt <= uft_pkg::CMDQ_CNT_W'(uft_pkg::CMDQ_DEPTH), "command queue overfilled")
  `ASSERT_IMPL(a_cmdq_pop_valid, pop, valid, "pop from empty command queue")

endmodule

// ===== design/uft_back.sv =====
// back end: register file, byte fifos and the result register
`include "assert_macros.svh"
module uft_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  uft_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_valid,
  input  logic          res_ready,
  output uft_pkg::res_t res
);

  logic [7:0]                     tx_q [uft_pkg::TX_DEPTH];
  logic [7:0]                     rx_q [uft_pkg::RX_DEPTH];
  logic [uft_pkg::TX_CNT_W-1:0]   tx_count, tx_count_next;
  logic [uft_pkg::RX_CNT_W-1:0]   rx_count, rx_count_next;
  logic [uft_pkg::TX_PTR_W-1:0]   tx_head, tx_tail;
  logic [uft_pkg::RX_PTR_W-1:0]   rx_head, rx_tail;
  logic [uft_pkg::CTRL_W-1:0]     tx_ctrl, tx_ctrl_next;
  logic [uft_pkg::CTRL_W-1:0]     rx_ctrl, rx_ctrl_next;
  logic [1:0]                     irq_en, irq_en_next;
  logic [uft_pkg::DIV_W-1:0]      divisor, divisor_next;

  logic        go;
  logic        tx_push, tx_pop, rx_push, rx_pop;
  logic        tx_full, rx_full;
  logic [31:0] rdata;
  logic        drop;
  logic [1:0]  ip_cur, ip_next;

  assign go      = cmd_valid && (!res_valid || res_ready);
  assign cmd_pop = go;
  assign tx_full = (tx_count == uft_pkg::TX_CNT_W'(uft_pkg::TX_DEPTH));
  assign rx_full = (rx_count == uft_pkg::RX_CNT_W'(uft_pkg::RX_DEPTH));

  // pending bits from the current state, for ip reads
  assign ip_cur[0] = uft_pkg::TX_CMP_W'(tx_count) <
                     uft_pkg::TX_CMP_W'(tx_ctrl[uft_pkg::WM_LSB +: uft_pkg::WM_W]);
  assign ip_cur[1] = uft_pkg::RX_CMP_W'(rx_count) >
                     uft_pkg::RX_CMP_W'(rx_ctrl[uft_pkg::WM_LSB +: uft_pkg::WM_W]);

  // pending bits after this beat
  assign ip_next[0] = uft_pkg::TX_CMP_W'(tx_count_next) <
                      uft_pkg::TX_CMP_W'(tx_ctrl_next[uft_pkg::WM_LSB +: uft_pkg::WM_W]);
  assign ip_next[1] = uft_pkg::RX_CMP_W'(rx_count_next) >
                      uft_pkg::RX_CMP_W'(rx_ctrl_next[uft_pkg::WM_LSB +: uft_pkg::WM_W]);

  always_comb begin
    tx_ctrl_next = tx_ctrl;
    rx_ctrl_next = rx_ctrl;
    irq_en_next  = irq_en;
    divisor_next = divisor;
    tx_push      = 1'b0;
    tx_pop       = 1'b0;
    rx_push      = 1'b0;
    rx_pop       = 1'b0;
    rdata        = '0;
    drop         = 1'b0;
    if (go) begin
      unique case (cmd.kind)
        uft_pkg::KIND_READ: begin
          unique case (cmd.addr)
            uft_pkg::REG_TXDATA: rdata[uft_pkg::FLAG_BIT] = tx_full;
            uft_pkg::REG_RXDATA: begin
              if (rx_count == '0) begin
                rdata[uft_pkg::FLAG_BIT] = 1'b1;
              end else begin
                rdata  = {24'd0, rx_q[rx_head]};
                rx_pop = 1'b1;
              end
            end
            uft_pkg::REG_TXCTRL: rdata = 32'(tx_ctrl);
            uft_pkg::REG_RXCTRL: rdata = 32'(rx_ctrl);
            uft_pkg::REG_IE:     rdata = 32'(irq_en);
            uft_pkg::REG_IP:     rdata = 32'(ip_cur);
            uft_pkg::REG_DIV:    rdata = 32'(divisor);
            default:             rdata = '0;
          endcase
        end
        uft_pkg::KIND_WRITE: begin
          unique case (cmd.addr)
            uft_pkg::REG_TXDATA: tx_push = !tx_full;
            uft_pkg::REG_TXCTRL: tx_ctrl_next = cmd.data[uft_pkg::CTRL_W-1:0] & uft_pkg::CTRL_MASK;
            uft_pkg::REG_RXCTRL: rx_ctrl_next = cmd.data[uft_pkg::CTRL_W-1:0] & uft_pkg::CTRL_MASK;
            uft_pkg::REG_IE:     irq_en_next = cmd.data[1:0];
            uft_pkg::REG_DIV:    divisor_next = cmd.data[uft_pkg::DIV_W-1:0];
            default:             ;
          endcase
        end
        uft_pkg::KIND_RX_BYTE: begin
          if (rx_ctrl[0]) begin
            rx_push = !rx_full;
            drop    = rx_full;
          end
        end
        uft_pkg::KIND_TX_READY: begin
          tx_pop = tx_ctrl[0] && (tx_count != '0);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    tx_count_next = tx_count;
    rx_count_next = rx_count;
    if (tx_push) begin
      tx_count_next = tx_count + 1'b1;
    end else if (tx_pop) begin
      tx_count_next = tx_count - 1'b1;
    end
    if (rx_push) begin
      rx_count_next = rx_count + 1'b1;
    end else if (rx_pop) begin
      rx_count_next = rx_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tx_push) begin
      tx_q[tx_tail] <= cmd.data[7:0];
    end
    if (rx_push) begin
      rx_q[rx_tail] <= cmd.data[7:0];
    end
    if (go) begin
      res.read_data    <= rdata;
      res.tx_valid     <= tx_pop;
      res.tx_byte      <= tx_pop ? tx_q[tx_head] : 8'd0;
      res.tx_two_stop  <= tx_ctrl_next[1];
      res.tx_irq       <= ip_next[0] & irq_en_next[0];
      res.rx_irq       <= ip_next[1] & irq_en_next[1];
      res.rx_dropped   <= drop;
      res.baud_divisor <= divisor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_count  <= '0;
      rx_count  <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      rx_head   <= '0;
      rx_tail   <= '0;
      tx_ctrl   <= '0;
      rx_ctrl   <= '0;
      irq_en    <= '0;
      divisor   <= uft_pkg::DIV_W'(uft_pkg::DIV_RESET);
      res_valid <= 1'b0;
    end else begin
      tx_count <= tx_count_next;
      rx_count <= rx_count_next;
      tx_ctrl  <= tx_ctrl_next;
      rx_ctrl  <= rx_ctrl_next;
      irq_en   <= irq_en_next;
      divisor  <= divisor_next;
      if (tx_push) begin
        tx_tail <= (tx_tail == uft_pkg::TX_PTR_W'(uft_pkg::TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
      end
      if (tx_pop) begin
        tx_head <= (tx_head == uft_pkg::TX_PTR_W'(uft_pkg::TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
      end
      if (rx_push) begin
        rx_tail <= (rx_tail == uft_pkg::RX_PTR_W'(uft_pkg::RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
      end
      if (rx_pop) begin
        rx_head <= (rx_head == uft_pkg::RX_PTR_W'(uft_pkg::RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
      end
      if (go) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `ASSERT_HOLDS(a_count_bound, (tx_count <= uft_pkg::TX_CNT_W'(uft_pkg::TX_DEPTH)) && (rx_count <= uft_pkg::RX_CNT_W'(uft_pkg::RX_DEPTH)), "fifo count beyond depth")
  `ASSERT_NEXT(a_tx_pop_count, go && tx_pop, (tx_count == $past(tx_count) - 1'b1) && res.tx_valid, "tx pop did not lower count")
  `ASSERT_IMPL(a_drop_full, res_valid && res.rx_dropped, rx_full, "rx drop without full fifo")

endmodule

// ===== design/uart_fifo_watermark_irq_top.sv =====
// top level of the uart register block with tx/rx byte fifos and watermark irqs
//
//  channel | dir | payload
//  s_*     | in  | tuser: req_type; tdata: reg_index, write_data, rx_byte
//  m_*     | out | tdata: read_data, tx_valid, tx_byte, tx_two_stop, tx_irq,
//          |     |        rx_irq, rx_dropped, baud_divisor
//
//  one beat a cycle unless m_* stalls; each beat is registered in the command queue
//  the back end runs each command against the register file and registers its result
//  while m_* stalls the two-entry command queue fills, then s_tready drops
//  rst is synchronous and needs one cycle; no clearing pass follows it
module uart_fifo_watermark_irq_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [uft_pkg::S_TDATA_W-1:0] s_tdata,  // reg_index, write_data, rx_byte, pad
  input  logic [uft_pkg::S_TUSER_W-1:0] s_tuser,  // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [uft_pkg::M_TDATA_W-1:0] m_tdata   // read_data, tx_valid, tx_byte,
                                                  // tx_two_stop, tx_irq, rx_irq,
                                                  // rx_dropped, baud_divisor, pad
);

  logic          q_full;
  logic          q_push;
  uft_pkg::cmd_t q_in;
  logic          q_valid;
  uft_pkg::cmd_t q_head;
  logic          q_pop;
  uft_pkg::res_t res;

  uft_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  uft_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .valid    (q_valid),
    .head_cmd (q_head),
    .pop      (q_pop)
  );

  uft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {3'd0, res.baud_divisor, res.rx_dropped, res.rx_irq, res.tx_irq,
                    res.tx_two_stop, res.tx_byte, res.tx_valid, res.read_data};

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the uart register block with tx/rx fifos and watermark irqs
`timescale 1ns / 1ps

module tb_top;
  import uft_pkg::*;

  typedef struct {
    kind_t       kind;
    reg_t        addr;
    logic [31:0] data;
    logic [7:0]  rxb;
  } uart_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  uart_cmd_t   pending_cmds[$];
  res_t        due_results[$];
  uart_cmd_t   cur_cmd;
  int          cmds_total = 0;
  int          cmds_taken = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          recv_stall = 0;

  // shadow copy of the register file and both fifos
  logic [7:0]        txq[TX_DEPTH];
  logic [7:0]        rxq[RX_DEPTH];
  int                tx_cnt = 0;
  int                tx_hd = 0;
  int                rx_cnt = 0;
  int                rx_hd = 0;
  logic [CTRL_W-1:0] txctrl = '0;
  logic [CTRL_W-1:0] rxctrl = '0;
  logic [1:0]        irq_en = '0;
  logic [DIV_W-1:0]  divr = DIV_W'(DIV_RESET);

  uart_fifo_watermark_irq_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] pending_irqs();
    logic [1:0] ip;
    ip[0] = tx_cnt < int'(txctrl[WM_LSB +: WM_W]);
    ip[1] = rx_cnt > int'(rxctrl[WM_LSB +: WM_W]);
    return ip;
  endfunction

  function automatic res_t apply_cmd(uart_cmd_t c);
    res_t       r;
    logic [1:0] ip;
    r = '0;
    case (c.kind)
      KIND_READ: begin
        case (c.addr)
          REG_TXDATA: r.read_data[FLAG_BIT] = tx_cnt >= TX_DEPTH;
          REG_RXDATA: begin
            if (rx_cnt == 0) begin
              r.read_data[FLAG_BIT] = 1'b1;
            end else begin
              r.read_data[7:0] = rxq[rx_hd];
              rx_hd = (rx_hd + 1) % RX_DEPTH;
              rx_cnt--;
            end
          end
          REG_TXCTRL: r.read_data = 32'(txctrl);
          REG_RXCTRL: r.read_data = 32'(rxctrl);
          REG_IE:     r.read_data = 32'(irq_en);
          REG_IP:     r.read_data = 32'(pending_irqs());
          REG_DIV:    r.read_data = 32'(divr);
          default: ;
        endcase
      end
      KIND_WRITE: begin
        case (c.addr)
          REG_TXDATA: begin
            if (tx_cnt < TX_DEPTH) begin
              txq[(tx_hd + tx_cnt) % TX_DEPTH] = c.data[7:0];
              tx_cnt++;
            end
          end
          REG_TXCTRL: txctrl = c.data[CTRL_W-1:0] & CTRL_MASK;
          REG_RXCTRL: rxctrl = c.data[CTRL_W-1:0] & CTRL_MASK;
          REG_IE:     irq_en = c.data[1:0];
          REG_DIV:    divr = c.data[DIV_W-1:0];
          default: ;
        endcase
      end
      KIND_RX_BYTE: begin
        if (rxctrl[0]) begin
          if (rx_cnt < RX_DEPTH) begin
            rxq[(rx_hd + rx_cnt) % RX_DEPTH] = c.rxb;
            rx_cnt++;
          end else begin
            r.rx_dropped = 1'b1;
          end
        end
      end
      default: begin
        if (txctrl[0] && tx_cnt > 0) begin
          r.tx_byte  = txq[tx_hd];
          r.tx_valid = 1'b1;
          tx_hd = (tx_hd + 1) % TX_DEPTH;
          tx_cnt--;
        end
      end
    endcase
    ip = pending_irqs();
    r.tx_two_stop  = txctrl[1];
    r.tx_irq       = ip[0] & irq_en[0];
    r.rx_irq       = ip[1] & irq_en[1];
    r.baud_divisor = divr;
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic add_cmd(kind_t k, reg_t a, logic [31:0] d, logic [7:0] b);
    uart_cmd_t c;
    c.kind = k;
    c.addr = a;
    c.data = d;
    c.rxb  = b;
    pending_cmds.push_back(c);
  endtask

  task automatic add_bursts(int target);
    int          len;
    int          pick;
    logic [31:0] d;
    reg_t        ctl_regs[4];
    ctl_regs = '{REG_TXCTRL, REG_RXCTRL, REG_IE, REG_DIV};
    while (pending_cmds.size() < target) begin
      len  = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        case (pick)
          0, 1: add_cmd(KIND_WRITE, REG_TXDATA, $urandom, 8'($urandom));
          2, 3: add_cmd(KIND_TX_READY, reg_t'($urandom_range(0, 7)), $urandom, 8'($urandom));
          4, 5: add_cmd(KIND_RX_BYTE, reg_t'($urandom_range(0, 7)), $urandom, 8'($urandom));
          6, 7: add_cmd(KIND_READ, REG_RXDATA, $urandom, 8'($urandom));
          8: add_cmd(kind_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 7)),
                     $urandom, 8'($urandom));
          default: begin
            d = $urandom;
            if ($urandom_range(0, 3) != 0) d[0] = 1'b1;
            add_cmd(KIND_WRITE, ctl_regs[$urandom_range(0, 3)], d, 8'($urandom));
            add_cmd(KIND_READ, reg_t'($urandom_range(2, 6)), $urandom, 8'($urandom));
            break;
          end
        endcase
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(apply_cmd(cur_cmd));
        cmds_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     (pending_cmds.size() < 200 || $urandom_range(0, 7) != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, cur_cmd.rxb, cur_cmd.data, cur_cmd.addr};
          s_tuser  <= cur_cmd.kind;
        end else begin
          if (pending_cmds.size() > 0) send_gap = $urandom_range(0, 2);
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.read_data    = m_tdata[31:0];
        got.tx_valid     = m_tdata[32];
        got.tx_byte      = m_tdata[40:33];
        got.tx_two_stop  = m_tdata[41];
        got.tx_irq       = m_tdata[42];
        got.rx_irq       = m_tdata[43];
        got.rx_dropped   = m_tdata[44];
        got.baud_divisor = m_tdata[60:45];
        if (due_results.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          cmp_field("read_data", want.read_data, got.read_data);
          cmp_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
          cmp_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
          cmp_field("tx_two_stop", 32'(want.tx_two_stop), 32'(got.tx_two_stop));
          cmp_field("tx_irq", 32'(want.tx_irq), 32'(got.tx_irq));
          cmp_field("rx_irq", 32'(want.rx_irq), 32'(got.rx_irq));
          cmp_field("rx_dropped", 32'(want.rx_dropped), 32'(got.rx_dropped));
          cmp_field("baud_divisor", 32'(want.baud_divisor), 32'(got.baud_divisor));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else if (pending_cmds.size() >= 200 && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    foreach (txq[i]) txq[i] = '0;
    foreach (rxq[i]) rxq[i] = '0;
    // reset values and empty fifo flags
    add_cmd(KIND_READ, REG_TXDATA, '0, '0);
    add_cmd(KIND_READ, REG_RXDATA, '0, '0);
    add_cmd(KIND_READ, REG_UNMAPPED, '0, '0);
    add_cmd(KIND_READ, REG_DIV, '0, '0);
    add_cmd(KIND_TX_READY, REG_TXDATA, '0, '0);
    // every register at its extreme, ignored offsets too
    add_cmd(KIND_WRITE, REG_TXCTRL, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_WRITE, REG_RXCTRL, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_WRITE, REG_IE, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_WRITE, REG_IP, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_WRITE, REG_RXDATA, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_WRITE, REG_UNMAPPED, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_WRITE, REG_DIV, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_READ, REG_IP, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_TX_READY, REG_UNMAPPED, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_RX_BYTE, REG_UNMAPPED, 32'hffff_ffff, 8'hff);
    add_cmd(KIND_RX_BYTE, REG_TXDATA, '0, 8'h00);
    add_cmd(KIND_READ, REG_RXDATA, '0, '0);
    add_cmd(KIND_READ, REG_RXDATA, '0, '0);
    add_cmd(KIND_WRITE, REG_TXDATA, 32'hffff_ffff, 8'h00);
    add_cmd(KIND_TX_READY, REG_TXDATA, '0, '0);
    // back to all zeros, rx byte while disabled
    add_cmd(KIND_WRITE, REG_DIV, '0, '0);
    add_cmd(KIND_WRITE, REG_TXCTRL, '0, '0);
    add_cmd(KIND_WRITE, REG_RXCTRL, '0, '0);
    add_cmd(KIND_RX_BYTE, REG_RXDATA, '0, 8'h5a);
    add_cmd(KIND_WRITE, REG_IE, '0, '0);
    add_bursts(1625);
    cmds_total = pending_cmds.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (cmds_taken < cmds_total) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
